// ----- design/lkvc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg: shared definitions for the LRU key/value cache
// Default sizes, register layout, mode codes and the per-cell control word.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int              CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } mode_t;

  // control handed to each cell of the recency chain
  typedef struct packed {
    logic clear;   // drop the entry
    logic shift;   // take the upstream neighbor's entry
    logic limit;   // position lies below the capacity limit
  } cell_ctl_t;

endpackage : lkvc_pkg
`default_nettype wire

// ----- design/lkvc_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_cell: one position of the recency chain
// Holds a key, a value and a valid bit. Compares its key with the lookup
// key and, when told to shift, takes the entry of its upstream neighbor.
// ----------------------------------------------------------------------------
module lkvc_cell #(
  parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lkvc_pkg::cell_ctl_t   ctl,
  input  wire logic [KEY_BITS-1:0]   lookup_key,
  input  wire logic [KEY_BITS-1:0]   up_key,
  input  wire logic [VALUE_BITS-1:0] up_value,
  input  wire logic                  up_valid,
  output logic [KEY_BITS-1:0]        key,
  output logic [VALUE_BITS-1:0]      value,
  output logic                       valid,
  output logic                       match
);

  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  valid_r, valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift) begin
      // an entry pushed past the capacity limit is the one evicted
      valid_nxt = up_valid & ctl.limit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key_r   <= up_key;
      value_r <= up_value;
    end
  end

  assign key   = key_r;
  assign value = value_r;
  assign valid = valid_r;
  assign match = valid_r && (key_r == lookup_key);

endmodule : lkvc_cell
`default_nettype wire

// ----- design/lru_key_value_cache.sv -----
`default_nettype none
// A get word shows on the output in the cycle after it is accepted.
// Throughput: one word per cycle while in_stall is low; the key match across the
// cell chain and the recency shift both complete in the accepting cycle.
// Input stalls only while a finished result waits on a stalled output.
// Reset (synchronous, rst_n low): store empty, capacity 16, output idle.
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value store, LRU replacement
// Entries sit in a chain ordered by recency, position 0 most recent. A hit
// or an insert moves the entry to the head and shifts the younger ones down.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [lkvc_pkg::CAP_W-1:0]   cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_mode,
  input  wire logic [KEY_BITS-1:0]          in_key,
  input  wire logic signed [VALUE_BITS-1:0] in_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_hit,
  output logic signed [VALUE_BITS-1:0]      out_read_value
);

  logic [lkvc_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_hit_r;
  logic [VALUE_BITS-1:0]      out_value_r;

  logic                  accept, cfg_wr, is_put, hit_any, insert;
  logic [ENTRIES-1:0]    match, at_or_above, cell_valid;
  logic [VALUE_BITS-1:0] hit_value, head_value;
  logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
  logic [VALUE_BITS-1:0] cell_value [ENTRIES];
  lkvc_pkg::cell_ctl_t   ctl        [ENTRIES];

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign is_put    = (lkvc_pkg::mode_t'(in_mode) == lkvc_pkg::MODE_PUT);
  assign hit_any   = |match;
  assign insert    = accept & is_put & ~hit_any;

  // keys are unique among live entries, so the match vector is one-hot or zero
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | ({VALUE_BITS{match[i]}} & cell_value[i]);
    end
  end

  assign head_value = is_put ? in_value : hit_value;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_chain
      // a hit at or below this position pulls the younger entries down
      assign at_or_above[g] = |(match >> g);

      always_comb begin
        ctl[g].clear = cfg_wr;
        ctl[g].shift = insert | (accept & hit_any & at_or_above[g]);
        ctl[g].limit = (cap_r == '0) ? (g == 0) : (int'(cap_r) > g);
      end

      if (g == 0) begin : g_head
        lkvc_cell #(
          .KEY_BITS  (KEY_BITS),
          .VALUE_BITS(VALUE_BITS)
        ) u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .ctl       (ctl[g]),
          .lookup_key(in_key),
          .up_key    (in_key),
          .up_value  (head_value),
          .up_valid  (1'b1),
          .key       (cell_key[g]),
          .value     (cell_value[g]),
          .valid     (cell_valid[g]),
          .match     (match[g])
        );
      end else begin : g_body
        lkvc_cell #(
          .KEY_BITS  (KEY_BITS),
          .VALUE_BITS(VALUE_BITS)
        ) u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .ctl       (ctl[g]),
          .lookup_key(in_key),
          .up_key    (cell_key[g-1]),
          .up_value  (cell_value[g-1]),
          .up_valid  (cell_valid[g-1]),
          .key       (cell_key[g]),
          .value     (cell_value[g]),
          .valid     (cell_valid[g]),
          .match     (match[g])
        );
      end
    end
  endgenerate

  always_comb begin
    cap_nxt = cfg_wr ? cfg_data : cap_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (accept && !is_put) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= lkvc_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_put) begin
      out_hit_r   <= hit_any;
      out_value_r <= hit_any ? hit_value : '1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_value_r;

  // live entries always form an unbroken run from the head
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + 1'b1) & cell_valid) == '0)
    else $error("valid entries not contiguous from head");

  a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("key matched in more than one entry");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (cell_valid == '0))
    else $error("store not empty after capacity write");

  a_get_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_put) |=> out_valid)
    else $error("accepted get gave no result");

endmodule : lru_key_value_cache
`default_nettype wire

// ----- tb/tb_lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache: self-checking bench for the LRU key/value cache
// Drives get and put words with random gaps against a randomly stalling
// output, predicts every read with a behavioral LRU store kept in the bench,
// and walks the capacity register through its extremes and random settings.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS     = lkvc_pkg::ENTRIES_DEF;
  localparam int KW         = lkvc_pkg::KEY_BITS_DEF;
  localparam int VW         = lkvc_pkg::VALUE_BITS_DEF;
  localparam int CW         = lkvc_pkg::CAP_W;
  localparam int DRAIN_WAIT = 4;
  localparam int WD_LIMIT   = 2000;

  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_NEG1 = '1;

  typedef struct {
    bit                   hit;
    logic signed [VW-1:0] value;
  } read_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [CW-1:0] cfg_data = '0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_mode = lkvc_pkg::MODE_GET;
  logic [KW-1:0]        in_key = '0;
  logic signed [VW-1:0] in_value = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_hit;
  logic signed [VW-1:0] out_read_value;

  lru_key_value_cache uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_read_value(out_read_value)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioral LRU store
  // --------------------------------------------------------------------------
  logic [CW-1:0]        m_cap;
  bit   [KW-1:0]        m_key   [NSLOTS];
  logic signed [VW-1:0] m_val   [NSLOTS];
  bit                   m_valid [NSLOTS];
  int unsigned          m_rank  [NSLOTS];
  int unsigned          m_occ;

  read_word_t pending_reads[$];
  int         errors = 0;

  bit input_quiet  = 1'b0;
  bit output_quiet = 1'b0;

  function automatic int unsigned live_limit(input logic [CW-1:0] cap);
    if (cap == 0) return 1;
    if (cap > NSLOTS) return NSLOTS;
    return int'(cap);
  endfunction

  function automatic void store_clear();
    for (int i = 0; i < NSLOTS; i++) begin
      m_valid[i] = 1'b0;
      m_rank[i]  = 0;
      m_key[i]   = '0;
      m_val[i]   = '0;
    end
    m_occ = 0;
  endfunction

  // slot s becomes most recent; the valid entries that were younger age by one
  function automatic void store_touch(input int s);
    int unsigned r;
    r = m_rank[s];
    for (int i = 0; i < NSLOTS; i++)
      if (m_valid[i] && m_rank[i] < r) m_rank[i]++;
    m_rank[s] = 0;
  endfunction

  function automatic void store_access(input lkvc_pkg::mode_t mode,
                                       input bit [KW-1:0] key,
                                       input logic signed [VW-1:0] val,
                                       output bit gives_read, output read_word_t rw);
    int  slot;
    int  free_slot;
    bit  evicted;
    slot      = -1;
    free_slot = -1;
    evicted   = 1'b0;
    rw.hit    = 1'b0;
    rw.value  = VAL_NEG1;
    for (int i = 0; i < NSLOTS; i++)
      if (slot < 0 && m_valid[i] && m_key[i] == key) slot = i;
    gives_read = (mode == lkvc_pkg::MODE_GET);
    if (mode == lkvc_pkg::MODE_GET) begin
      if (slot >= 0) begin
        store_touch(slot);
        rw.hit   = 1'b1;
        rw.value = m_val[slot];
      end
    end else if (slot >= 0) begin
      m_val[slot] = val;
      store_touch(slot);
    end else begin
      if (m_occ >= live_limit(m_cap)) begin
        for (int i = 0; i < NSLOTS; i++)
          if (!evicted && m_valid[i] && m_rank[i] + 1 == m_occ) begin
            m_valid[i] = 1'b0;
            m_rank[i]  = 0;
            evicted    = 1'b1;
          end
        if (m_occ > 0) m_occ--;
      end
      for (int i = 0; i < NSLOTS; i++)
        if (m_valid[i]) m_rank[i]++;
      for (int i = 0; i < NSLOTS; i++)
        if (free_slot < 0 && !m_valid[i]) free_slot = i;
      if (free_slot >= 0) begin
        m_key[free_slot]   = key;
        m_val[free_slot]   = val;
        m_valid[free_slot] = 1'b1;
        m_rank[free_slot]  = 0;
        m_occ++;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(input lkvc_pkg::mode_t mode, input bit [KW-1:0] key,
                           input logic signed [VW-1:0] val);
    int         gap;
    bit         gives_read;
    read_word_t rw;
    gap = input_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_key   <= key;
    in_value <= val;
    do @(posedge clk); while (in_stall);
    store_access(mode, key, val, gives_read, rw);
    if (gives_read) pending_reads.push_back(rw);
  endtask

  // wait for every read to come back, then for the tail of any put
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CW-1:0] cap);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_cap = cap;
    store_clear();
  endtask

  // output stall in segments: short runs of either level, now and then a long stall
  int stall_left = 0;
  always @(posedge clk) begin
    int r;
    if (!rst_n || output_quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 7);
      end else if (r < 92) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    read_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected read word hit %0b value %0d", $time, out_hit,
                 out_read_value);
        errors++;
      end else begin
        exp_w = pending_reads.pop_front();
        if (out_hit !== exp_w.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_w.hit, out_hit);
          errors++;
        end
        if (out_read_value !== exp_w.value) begin
          $display("%0t: read_value expected %0d actual %0d", $time, exp_w.value,
                   out_read_value);
          errors++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else if (idle_cycles + 1 >= WD_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WD_LIMIT);
        $display("** lru_key_value_cache: FAILED **");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_basic_access();
    send_word(lkvc_pkg::MODE_GET, 16'h0000, 32'sd5);       // empty store
    send_word(lkvc_pkg::MODE_PUT, 16'h0000, VAL_MIN);
    send_word(lkvc_pkg::MODE_PUT, 16'hffff, VAL_MAX);
    send_word(lkvc_pkg::MODE_GET, 16'h0000, '0);
    send_word(lkvc_pkg::MODE_GET, 16'hffff, '0);
    send_word(lkvc_pkg::MODE_PUT, 16'h0000, VAL_NEG1);     // update in place
    send_word(lkvc_pkg::MODE_GET, 16'h0000, '0);           // hit that reads all ones
    send_word(lkvc_pkg::MODE_GET, 16'h0001, '0);
    send_word(lkvc_pkg::MODE_PUT, 16'h5a5a, '0);
    send_word(lkvc_pkg::MODE_GET, 16'h5a5a, VAL_MAX);
  endtask

  task automatic test_lru_order();
    write_capacity(5'd2);
    send_word(lkvc_pkg::MODE_PUT, 16'h0001, 32'sd11);
    send_word(lkvc_pkg::MODE_PUT, 16'h0002, 32'sd22);
    send_word(lkvc_pkg::MODE_GET, 16'h0001, '0);           // 2 is now the oldest
    send_word(lkvc_pkg::MODE_PUT, 16'h0003, 32'sd33);
    send_word(lkvc_pkg::MODE_GET, 16'h0002, '0);
    send_word(lkvc_pkg::MODE_GET, 16'h0001, '0);
    send_word(lkvc_pkg::MODE_GET, 16'h0003, '0);
  endtask

  task automatic test_capacity_edges();
    write_capacity(5'd1);
    send_word(lkvc_pkg::MODE_PUT, 16'h0007, 32'sh1234_5678);
    send_word(lkvc_pkg::MODE_PUT, 16'h0008, -32'sd77);
    send_word(lkvc_pkg::MODE_GET, 16'h0007, '0);
    send_word(lkvc_pkg::MODE_GET, 16'h0008, '0);
    write_capacity(5'd0);                        // behaves as one entry
    send_word(lkvc_pkg::MODE_PUT, 16'h0009, 32'sd9);
    send_word(lkvc_pkg::MODE_PUT, 16'h000a, 32'sd10);
    send_word(lkvc_pkg::MODE_GET, 16'h0009, '0);
    send_word(lkvc_pkg::MODE_GET, 16'h000a, '0);
  endtask

  task automatic run_random_phase(input logic [CW-1:0] cap, input int n_items);
    bit [KW-1:0]          pool[20];
    int                   psize;
    int                   r;
    lkvc_pkg::mode_t      mode;
    bit [KW-1:0]          key;
    logic signed [VW-1:0] val;
    write_capacity(cap);
    input_quiet  = ($urandom_range(0, 3) == 0);
    output_quiet = ($urandom_range(0, 3) == 0);
    psize = live_limit(cap) + $urandom_range(0, 3);
    for (int i = 0; i < 20; i++) begin
      r = $urandom_range(0, 19);
      pool[i] = (r == 0) ? '0 : (r == 1) ? '1 : KW'($urandom);
    end
    for (int n = 0; n < n_items; n++) begin
      mode = ($urandom_range(0, 1) == 0) ? lkvc_pkg::MODE_GET : lkvc_pkg::MODE_PUT;
      key  = ($urandom_range(0, 9) == 0) ? KW'($urandom) : pool[$urandom_range(0, psize-1)];
      r = $urandom_range(0, 15);
      case (r)
        0:       val = VAL_MIN;
        1:       val = VAL_MAX;
        2:       val = VAL_NEG1;
        3:       val = '0;
        default: val = VW'($urandom);
      endcase
      send_word(mode, key, val);
    end
  endtask

  task automatic test_random_traffic();
    logic [CW-1:0] caps[12];
    caps = '{5'd31, 5'd16, 5'd1, 5'd0, 5'd2, 5'd3, 5'd5, 5'd8,
             5'd15, 5'd17, 5'd4, 5'd16};
    for (int p = 0; p < 12; p++) begin
      if (p == 10) caps[p] = CW'($urandom);
      run_random_phase(caps[p], 150);
    end
  endtask

  initial begin
    m_cap = lkvc_pkg::CAP_RESET;
    store_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_access();
    test_lru_order();
    test_capacity_edges();
    test_random_traffic();
    input_quiet  = 1'b0;
    output_quiet = 1'b0;
    drain();
    if (errors == 0)
      $display("** lru_key_value_cache: PASSED **");
    else
      $display("** lru_key_value_cache: FAILED **");
    $finish;
  end

endmodule
